FILE: src/srd_pkg.sv
// Shared types, constants and helpers for the signed restoring divider.
package srd_pkg;

    localparam int WIDTH = 32;

    typedef logic [WIDTH-1:0] word_t;

    localparam word_t WORD_ZERO = word_t'(0);
    localparam word_t INT_ONE   = word_t'(1);

    // One in-flight division as it moves down the pipeline.
    typedef struct packed {
        word_t rem;       // partial remainder
        word_t quo;       // remaining dividend bits shifted out, quotient bits shifted in
        word_t dvs;       // divisor magnitude
        logic  n_neg;     // dividend was negative (signed mode)
        logic  d_neg;     // divisor was negative (signed mode)
        logic  want_rem;  // return remainder instead of quotient
    } stage_t;

    function automatic word_t negate_w(input word_t x);
        return ~x + INT_ONE;
    endfunction

endpackage

FILE: src/signed_restoring_divider_core.sv
// Top level of the pipelined signed/unsigned restoring divider.
// Each result passes the entry stage, all step stages and the output buffer head.
// Throughput: one transaction per cycle unless halted; one trial subtraction per stage.
// A two-entry output buffer lets the pipeline keep accepting while a result waits.
// Reset (rst_n low, asynchronous) clears all valid bits; payload registers keep no reset.
module signed_restoring_divider_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  srd_pkg::word_t dividend,
    input  srd_pkg::word_t divisor,
    input  logic           is_signed,
    input  logic           want_remainder,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output srd_pkg::word_t result
);
    import srd_pkg::*;

    // Stage 0 holds operand magnitudes; stage k (1..WIDTH) holds the state after k steps.
    logic   pipe_valid [WIDTH+1];
    stage_t pipe_data  [WIDTH+1];
    // Whole pipeline moves together; it halts only when the output buffer is full.
    logic   advance;

    assign req_stall = ~advance;

    srd_pre u_pre (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .load_valid     (req_valid),
        .dividend       (dividend),
        .divisor        (divisor),
        .is_signed      (is_signed),
        .want_remainder (want_remainder),
        .stage_valid    (pipe_valid[0]),
        .stage_data     (pipe_data[0])
    );

    // One restoring step per stage, most significant dividend bit first.
    for (genvar k = 1; k <= WIDTH; k++)
    begin : g_step
        srd_step u_step (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .prev_valid  (pipe_valid[k-1]),
            .prev_data   (pipe_data[k-1]),
            .stage_valid (pipe_valid[k]),
            .stage_data  (pipe_data[k])
        );
    end

    // Apply the sign rules (quotient by sign mismatch, remainder by dividend) and buffer.
    srd_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .last_valid (pipe_valid[WIDTH]),
        .last_data  (pipe_data[WIDTH]),
        .advance    (advance),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .result     (result)
    );

    // An accepted request must show up in the entry stage on the next edge.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> pipe_valid[0])
        else $error("accepted transaction missing from entry stage");

    // A halted pipeline must keep its entry stage contents.
    a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && pipe_valid[0]) |=> (pipe_valid[0] && $stable(pipe_data[0])))
        else $error("entry stage changed while pipeline halted");

endmodule

FILE: src/srd_pre.sv
// Entry stage: take operand magnitudes and register the first pipeline stage.
module srd_pre (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           load_valid,
    input  srd_pkg::word_t dividend,
    input  srd_pkg::word_t divisor,
    input  logic           is_signed,
    input  logic           want_remainder,
    output logic           stage_valid,
    output srd_pkg::stage_t stage_data
);
    import srd_pkg::*;

    logic   stage_valid_reg;
    stage_t stage_data_reg;
    stage_t stage_data_next;
    logic   n_neg;
    logic   d_neg;

    always_comb
    begin
        n_neg = is_signed & dividend[WIDTH-1];
        d_neg = is_signed & divisor[WIDTH-1];
        stage_data_next.rem      = WORD_ZERO;
        stage_data_next.quo      = n_neg ? negate_w(dividend) : dividend;
        stage_data_next.dvs      = d_neg ? negate_w(divisor) : divisor;
        stage_data_next.n_neg    = n_neg;
        stage_data_next.d_neg    = d_neg;
        stage_data_next.want_rem = want_remainder;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            stage_valid_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_valid)
        begin
            stage_data_reg <= stage_data_next;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage_data  = stage_data_reg;

endmodule

FILE: src/srd_step.sv
// One restoring-division step: shift in a dividend bit, trial subtract, register.
module srd_step (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            prev_valid,
    input  srd_pkg::stage_t prev_data,
    output logic            stage_valid,
    output srd_pkg::stage_t stage_data
);
    import srd_pkg::*;

    logic           stage_valid_reg;
    stage_t         stage_data_reg;
    stage_t         stage_data_next;
    logic [WIDTH:0] shifted;
    logic [WIDTH+1:0] diff;
    logic           ge;

    always_comb
    begin
        shifted = {prev_data.rem, prev_data.quo[WIDTH-1]};
        diff    = {1'b0, shifted} - {2'b00, prev_data.dvs};
        ge      = ~diff[WIDTH+1];
        stage_data_next     = prev_data;
        stage_data_next.rem = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        stage_data_next.quo = {prev_data.quo[WIDTH-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            stage_valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && prev_valid)
        begin
            stage_data_reg <= stage_data_next;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage_data  = stage_data_reg;

    // With a nonzero divisor the partial remainder always stays below it.
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && (stage_data_reg.dvs != WORD_ZERO))
            |-> (stage_data_reg.rem < stage_data_reg.dvs))
        else $error("partial remainder not below divisor");

endmodule

FILE: src/srd_out.sv
// Sign correction and two-entry output buffer that decouples the response side.
module srd_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            last_valid,
    input  srd_pkg::stage_t last_data,
    output logic            advance,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output srd_pkg::word_t  result
);
    import srd_pkg::*;

    logic  head_valid_reg;
    word_t head_reg;
    logic  spare_valid_reg;
    word_t spare_reg;
    word_t fixed;
    logic  push;
    logic  pop;

    always_comb
    begin
        if (last_data.want_rem)
        begin
            fixed = last_data.n_neg ? negate_w(last_data.rem) : last_data.rem;
        end
        else
        begin
            fixed = (last_data.n_neg ^ last_data.d_neg) ? negate_w(last_data.quo)
                                                        : last_data.quo;
        end
    end

    assign advance = ~spare_valid_reg;
    assign push    = last_valid & advance;
    assign pop     = head_valid_reg & ~rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (pop || !head_valid_reg)
        begin
            head_valid_reg  <= spare_valid_reg | push;
            spare_valid_reg <= spare_valid_reg & push;
        end
        else if (push)
        begin
            spare_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !head_valid_reg)
        begin
            head_reg <= spare_valid_reg ? spare_reg : fixed;
            if (push)
            begin
                spare_reg <= fixed;
            end
        end
        else if (push)
        begin
            spare_reg <= fixed;
        end
    end

    assign rsp_valid = head_valid_reg;
    assign result    = head_reg;

    a_spare_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        spare_valid_reg |-> head_valid_reg)
        else $error("spare entry filled while head is empty");

    a_full_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (spare_valid_reg && rsp_stall) |=> spare_valid_reg)
        else $error("spare entry lost while response is stalled");

endmodule

FILE: bench/signed_restoring_divider_core_tb.sv
// Self-checking testbench for the pipelined signed/unsigned restoring divider.
module signed_restoring_divider_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srd_pkg::*;

    localparam int CLK_HALF      = 6;      // 12 ns period
    localparam int RESET_CYCLES  = 6;
    localparam int DRAIN_CYCLES  = 48;     // extra time after the last result is checked
    localparam int WATCHDOG_MAX  = 5000;   // cycles with no transaction on either side
    localparam int RANDOM_PER_PHASE = 157; // four pacing phases, about 650 with the corners

    localparam word_t MIN_NEG  = {1'b1, {(WIDTH-1){1'b0}}};
    localparam word_t MAX_POS  = {1'b0, {(WIDTH-1){1'b1}}};
    localparam word_t ALL_ONES = {WIDTH{1'b1}};

    // One pending quotient/remainder, kept with its operands for reporting.
    typedef struct {
        word_t dividend;
        word_t divisor;
        bit    is_signed;
        bit    want_remainder;
        word_t quotient_or_rem;
    } div_expect_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    word_t dividend = '0;
    word_t divisor = '0;
    logic  is_signed = 1'b0;
    logic  want_remainder = 1'b0;
    logic  rsp_valid;
    logic  rsp_stall = 1'b0;
    word_t result;

    div_expect_t pending_results[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          src_idle_pct = 0;   // chance in 100 that the sender sits out a cycle
    int          sink_stall_pct = 0; // chance in 100 that the receiver stalls a cycle

    signed_restoring_divider_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .dividend       (dividend),
        .divisor        (divisor),
        .is_signed      (is_signed),
        .want_remainder (want_remainder),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .result         (result)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Compute quotient or remainder with a bit-serial restoring recurrence.
    // The partial remainder carries one extra bit so that divisors with the
    // top bit set still compare correctly; a zero divisor subtracts every step.
    function automatic word_t predict_division(word_t num_in, word_t den_in,
                                               bit sgn, bit rem_sel);
        bit              num_neg;
        bit              den_neg;
        word_t           num;
        word_t           den;
        word_t           quo;
        logic [WIDTH:0]  part;
        num_neg = sgn && num_in[WIDTH-1];
        den_neg = sgn && den_in[WIDTH-1];
        num = num_neg ? word_t'(0 - num_in) : num_in;
        den = den_neg ? word_t'(0 - den_in) : den_in;
        quo = '0;
        part = '0;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            part = {part[WIDTH-1:0], num[i]};
            if (part >= {1'b0, den})
            begin
                part = part - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        // Remainder follows the dividend's sign; quotient flips on mixed signs.
        if (rem_sel)
            return num_neg ? word_t'(0 - part[WIDTH-1:0]) : part[WIDTH-1:0];
        return (num_neg != den_neg) ? word_t'(0 - quo) : quo;
    endfunction

    // Offer one division request; hold it until the block takes it, then
    // record the expected answer. Returns at the falling edge after acceptance.
    task automatic send_division(word_t n, word_t d, bit sgn, bit rem_sel);
        div_expect_t exp_item;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid      <= 1'b1;
        dividend       <= n;
        divisor        <= d;
        is_signed      <= sgn;
        want_remainder <= rem_sel;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        exp_item.dividend        = n;
        exp_item.divisor         = d;
        exp_item.is_signed       = sgn;
        exp_item.want_remainder  = rem_sel;
        exp_item.quotient_or_rem = predict_division(n, d, sgn, rem_sel);
        pending_results = {pending_results, exp_item};
        @(negedge clk);
    endtask

    // Run one operand pair through all four mode combinations.
    task automatic send_all_modes(word_t n, word_t d);
        for (int m = 0; m < 4; m++)
            send_division(n, d, m[1], m[0]);
    endtask

    // Draw an operand biased toward the interesting corners of the range.
    function automatic word_t random_operand(bit allow_zero);
        case ($urandom_range(11))
            0, 1, 2, 3: return $urandom;
            4:          return $urandom_range(1, 15);
            5:          return word_t'(0 - $urandom_range(1, 15));
            6:          return MIN_NEG + $urandom_range(0, 3);
            7:          return MAX_POS - $urandom_range(0, 3);
            8:          return word_t'($urandom) >> $urandom_range(0, WIDTH - 1);
            9:          return ALL_ONES;
            10:         return allow_zero ? '0 : word_t'(1);
            default:    return word_t'($urandom) | MIN_NEG;
        endcase
    endfunction

    // Largest magnitudes, smallest operands and mixed signs.
    task automatic test_extremes();
        send_all_modes(ALL_ONES, word_t'(1));
        send_all_modes(MAX_POS, MIN_NEG);
        send_division(word_t'(0 - 7), word_t'(2), 1'b1, 1'b0);
        send_division(word_t'(0 - 7), word_t'(2), 1'b1, 1'b1);
        send_division(word_t'(7), word_t'(0 - 2), 1'b1, 1'b1);
        send_division('0, ALL_ONES, 1'b0, 1'b0);
    endtask

    // Zero divisor is not trapped: all-ones quotient magnitude, remainder is the dividend.
    task automatic test_divide_by_zero();
        send_all_modes(MIN_NEG + word_t'(5), '0);
        send_division(MAX_POS, '0, 1'b1, 1'b0);
    endtask

    // Most negative dividend over minus one wraps back to itself.
    task automatic test_most_negative();
        send_all_modes(MIN_NEG, ALL_ONES);
        send_division(ALL_ONES, MIN_NEG, 1'b1, 1'b0);
    endtask

    // Unsigned divisors with the top bit set need the extra remainder bit.
    task automatic test_wide_divisor();
        send_division(ALL_ONES, MIN_NEG + word_t'(1), 1'b0, 1'b0);
        send_division(ALL_ONES, MIN_NEG + word_t'(1), 1'b0, 1'b1);
    endtask

    // Random operands and modes under one pacing setting.
    task automatic test_random_ops(int src_pct, int sink_pct, int count);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int k = 0; k < count; k++)
            send_division(random_operand(1'b0), random_operand($urandom_range(7) == 0),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // Receiver back-pressure: draw a new stall decision every falling edge.
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Compare every accepted result against the oldest pending expectation.
    always @(posedge clk)
    begin
        div_expect_t exp_item;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h with nothing pending", $time, result);
                error_count++;
            end
            else
            begin
                exp_item = pending_results.pop_front();
                if (result !== exp_item.quotient_or_rem)
                begin
                    $display("%0t: %h / %h signed=%0b rem=%0b expected %h actual %h",
                             $time, exp_item.dividend, exp_item.divisor,
                             exp_item.is_signed, exp_item.want_remainder,
                             exp_item.quotient_or_rem, result);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run: count cycles in which neither side moves a transaction.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("%0t: watchdog expired with %0d results pending",
                     $time, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        // Hold reset, then release it away from the sampling edge.
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corners at full speed.
        test_extremes();
        test_divide_by_zero();
        test_most_negative();
        test_wide_divisor();

        // Random traffic: no idling, idle sender, stalling receiver, then both.
        test_random_ops(0, 0, RANDOM_PER_PHASE);
        test_random_ops(77, 0, RANDOM_PER_PHASE);
        test_random_ops(0, 77, RANDOM_PER_PHASE);
        test_random_ops(29, 29, RANDOM_PER_PHASE);

        // Drop the request, drain the pipeline, then give it time to misbehave.
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
src/srd_pkg.sv
src/srd_pre.sv
src/srd_step.sv
src/srd_out.sv
src/signed_restoring_divider_core.sv
bench/signed_restoring_divider_core_tb.sv
